>>> sv/lhs_pkg.sv
`timescale 1ns / 1ps

package lhs_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int FRACTION_BITS = 16;

    localparam int PERM_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = PERM_W + 1;
    localparam int DIM_W       = 8;
    localparam int SLOT_W      = 2;
    localparam int ROW_ENTRIES = 1 << SLOT_W;
    localparam int ROW_COUNT   = MAX_POINTS / ROW_ENTRIES;
    localparam int ROW_AW      = PERM_W - SLOT_W;
    localparam int ENTRY_W     = PERM_W + 1;
    localparam int ROW_W       = ROW_ENTRIES * ENTRY_W;
    localparam int PROD_W      = FRACTION_BITS + CNT_W;

    localparam int DIV_STEPS = FRACTION_BITS / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_BITS   = DIM_W + PERM_W + FRACTION_BITS;
    localparam int TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                     start;
        logic [PERM_W-1:0]        stratum;
        logic [FRACTION_BITS-1:0] draw;
        logic [CNT_W-1:0]         divisor;
    } lhs_div_req_t;

    // entry reads as its own index until marked
    function automatic logic [PERM_W-1:0] entry_get(input logic [ROW_W-1:0] row,
                                                     input logic [PERM_W-1:0] addr);
        logic [ENTRY_W-1:0] e;
        e = row[addr[SLOT_W-1:0]*ENTRY_W +: ENTRY_W];
        return e[PERM_W] ? e[PERM_W-1:0] : addr;
    endfunction

    function automatic logic [ROW_W-1:0] entry_put(input logic [ROW_W-1:0] row,
                                                    input logic [PERM_W-1:0] addr,
                                                    input logic [PERM_W-1:0] val);
        logic [ROW_W-1:0] r;
        r = row;
        r[addr[SLOT_W-1:0]*ENTRY_W +: ENTRY_W] = {1'b1, val};
        return r;
    endfunction

endpackage

>>> sv/lhs_ram.sv
`timescale 1ns / 1ps

module lhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/lhs_div.sv
`timescale 1ns / 1ps

module lhs_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lhs_pkg::lhs_div_req_t               req,
    output logic                                done,
    output logic [lhs_pkg::FRACTION_BITS-1:0]   quotient
);
    import lhs_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]         div_reg, div_next;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;

    logic [CNT_W:0]   r1, r2;
    logic [CNT_W-1:0] s1;
    logic             q1, q2;

    always_comb begin
        r1 = {rem_reg, frac_reg[FRACTION_BITS-1]};
        q1 = (r1 >= {1'b0, div_reg});
        if (q1) begin
            r1 = r1 - {1'b0, div_reg};
        end
        s1 = r1[CNT_W-1:0];
        r2 = {s1, frac_reg[FRACTION_BITS-2]};
        q2 = (r2 >= {1'b0, div_reg});
        if (q2) begin
            r2 = r2 - {1'b0, div_reg};
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        frac_next = frac_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.stratum};
            div_next  = req.divisor;
            frac_next = req.draw;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next  = r2[CNT_W-1:0];
            frac_next = {frac_reg[FRACTION_BITS-3:0], 2'b00};
            quo_next  = {quo_reg[FRACTION_BITS-3:0], q1, q2};
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        frac_reg <= frac_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/latin_hypercube_sample_generator.sv
`timescale 1ns / 1ps

// Latin hypercube sample generator.
// s_ channel: one uniform Q0.16 random draw per request. For each dimension the
// first point_count draws shuffle the stratum permutation and return nothing;
// the next point_count draws each return one coordinate on the m_ channel,
// tagged with dimension and point, m_tlast on the last point of a dimension and
// m_tuser on the last coordinate of the whole set.
// cfg_ channel: index 0 writes dim_count, index 1 writes point_count; a write
// restarts the set at dimension 0. Write only while no request is in flight.
// A shuffle request runs two reads and two writes of the permutation memory (one
// port each); a coordinate request runs through the 2-bit-per-cycle divider and
// then loads the output register. One request is worked at a time.
// The result sits in an output register, so a new draw is taken while it waits;
// a stalled m_ side stops the block only when a second coordinate is ready.
// Reset: registers go to dim_count = 1, point_count = 1, set restarted. The
// permutation memory needs no clearing; per-row valid bits mark written rows.

module latin_hypercube_sample_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lhs_pkg::FRACTION_BITS-1:0] s_tdata,   // random_draw
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dimension_index, point_index, coordinate, zero pad
    output logic [lhs_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,   // end_of_dimension
    output logic                              m_tuser,   // end_of_set
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lhs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lhs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lhs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_WRA  = 9'b000001000,
        S_WRB  = 9'b000010000,
        S_JRD  = 9'b000100000,
        S_JDAT = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [DIM_W-1:0]         dim_count_reg, dim_count_next;
    logic [CNT_W-1:0]         point_count_reg, point_count_next;
    logic [DIM_W-1:0]         dim_reg, dim_next;
    logic [PERM_W-1:0]        pos_reg, pos_next;
    logic                     phase_reg, phase_next;
    logic [ROW_COUNT-1:0]     row_valid_reg, row_valid_next;
    logic [FRACTION_BITS-1:0] draw_reg, draw_next;
    logic [CNT_W-1:0]         off_reg, off_next;
    logic [PERM_W-1:0]        j_reg, j_next;
    logic [ROW_W-1:0]         row_a_reg, row_a_next;
    logic [ROW_W-1:0]         row_b_reg, row_b_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic                     m_tuser_reg, m_tuser_next;

    logic [CNT_W-1:0]         n_eff;
    logic [DIM_W-1:0]         d_eff;
    logic [PROD_W-1:0]        prod;
    logic [CNT_W:0]           j_sum;
    logic [ROW_AW-1:0]        pos_row, j_row;
    logic                     same_row;
    logic [ROW_W-1:0]         rd_row, view_b, view_pos, wa, wb;
    logic [PERM_W-1:0]        val_a, val_b;
    logic                     ram_we;
    logic [ROW_AW-1:0]        ram_waddr, ram_raddr;
    logic [ROW_W-1:0]         ram_wdata;
    lhs_div_req_t             div_req;
    logic                     div_done;
    logic [FRACTION_BITS-1:0] div_quo;
    logic                     in_fire, out_load, cfg_hit, eod, eos;

    lhs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROW_COUNT)
    ) u_perm_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_row)
    );

    lhs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_comb begin
        if (point_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (point_count_reg > CNT_W'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = point_count_reg;
        end
        d_eff = (dim_count_reg == '0) ? DIM_W'(1) : dim_count_reg;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_DIM_COUNT) ||
                                     (cfg_index == REG_POINT_COUNT));

    assign prod     = PROD_W'(s_tdata) * PROD_W'(n_eff - {1'b0, pos_reg});
    assign j_sum    = {1'b0, 1'b0, pos_reg} + {1'b0, off_reg};
    assign pos_row  = pos_reg[PERM_W-1:SLOT_W];
    assign j_row    = j_reg[PERM_W-1:SLOT_W];
    assign same_row = (pos_row == j_row);

    // unwritten rows read with all marks clear
    assign view_b   = row_valid_reg[j_row] ? rd_row : '0;
    assign view_pos = row_valid_reg[pos_row] ? rd_row : '0;
    assign val_a    = entry_get(row_a_reg, pos_reg);
    assign val_b    = entry_get(view_b, j_reg);

    always_comb begin
        wa = entry_put(row_a_reg, pos_reg, val_b);
        wb = entry_put(view_b, j_reg, val_a);
        if (same_row) begin
            wa = entry_put(wa, j_reg, val_a);
            wb = entry_put(wb, pos_reg, val_b);
        end
    end

    assign ram_raddr = (state_reg == S_RDB) ? j_row : pos_row;
    assign ram_we    = (state_reg == S_WRA) || (state_reg == S_WRB);
    assign ram_waddr = (state_reg == S_WRA) ? pos_row : j_row;
    assign ram_wdata = (state_reg == S_WRA) ? wa : row_b_reg;

    assign div_req.start   = (state_reg == S_JDAT);
    assign div_req.stratum = entry_get(view_pos, pos_reg);
    assign div_req.draw    = draw_reg;
    assign div_req.divisor = n_eff;

    assign eod      = ({1'b0, pos_reg} == n_eff - CNT_W'(1));
    assign eos      = eod && (dim_reg == d_eff - DIM_W'(1));
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next       = state_reg;
        dim_count_next   = dim_count_reg;
        point_count_next = point_count_reg;
        dim_next         = dim_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        row_valid_next   = row_valid_reg;
        draw_next        = draw_reg;
        off_next         = off_reg;
        j_next           = j_reg;
        row_a_next       = row_a_reg;
        row_b_next       = row_b_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        m_tuser_next     = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    draw_next  = s_tdata;
                    off_next   = prod[PROD_W-1:FRACTION_BITS];
                    state_next = phase_reg ? S_JRD : S_RDA;
                end
            end
            S_RDA: begin
                if (j_sum >= {1'b0, n_eff}) begin
                    j_next = PERM_W'(n_eff - CNT_W'(1));
                end else begin
                    j_next = j_sum[PERM_W-1:0];
                end
                state_next = S_RDB;
            end
            S_RDB: begin
                row_a_next = view_pos;
                state_next = S_WRA;
            end
            S_WRA: begin
                row_b_next              = wb;
                row_valid_next[pos_row] = 1'b1;
                state_next              = S_WRB;
            end
            S_WRB: begin
                row_valid_next[j_row] = 1'b1;
                if (eod) begin
                    pos_next   = '0;
                    phase_next = 1'b1;
                end else begin
                    pos_next = pos_reg + PERM_W'(1);
                end
                state_next = S_IDLE;
            end
            S_JRD: begin
                state_next = S_JDAT;
            end
            S_JDAT: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'({div_quo, pos_reg, dim_reg});
                    m_tlast_next  = eod;
                    m_tuser_next  = eos;
                    if (eod) begin
                        pos_next       = '0;
                        phase_next     = 1'b0;
                        row_valid_next = '0;
                        dim_next       = eos ? '0 : dim_reg + DIM_W'(1);
                    end else begin
                        pos_next = pos_reg + PERM_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_hit) begin
            if (cfg_index == REG_DIM_COUNT) begin
                dim_count_next = cfg_data[DIM_W-1:0];
            end else begin
                point_count_next = cfg_data[CNT_W-1:0];
            end
            dim_next       = '0;
            pos_next       = '0;
            phase_next     = 1'b0;
            row_valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            dim_count_reg   <= DIM_W'(1);
            point_count_reg <= CNT_W'(1);
            dim_reg         <= '0;
            pos_reg         <= '0;
            phase_reg       <= 1'b0;
            row_valid_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            dim_count_reg   <= dim_count_next;
            point_count_reg <= point_count_next;
            dim_reg         <= dim_next;
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            row_valid_reg   <= row_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        draw_reg    <= draw_next;
        off_reg     <= off_next;
        j_reg       <= j_next;
        row_a_reg   <= row_a_next;
        row_b_reg   <= row_b_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
